>>> rtl/ibf_pkg.sv
// ----------------------------------------------------------------------------
// ibf_pkg
// Shared types and constants of the interleaved Bloom filter.
// ----------------------------------------------------------------------------
package ibf_pkg;

	localparam logic [63:0] XP1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] XP2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] XP3 = 64'h165667B19E3779F9;
	localparam logic [63:0] XP4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] XP5 = 64'h27D4EB2F165667C5;

	localparam int WORD_BITS = 64;
	localparam int BIT_SEL_W = 6;
	localparam logic [4:0] HASH_MIN = 5'd1;
	localparam logic [4:0] HASH_MAX = 5'd16;
	localparam logic [4:0] SIZE_MIN_LOG2 = 5'd6;
	localparam logic [4:0] HASH_CNT_RST = 5'd3;

	localparam logic CFG_HASH_COUNT = 1'b0;
	localparam logic CFG_SIZE_LOG2 = 1'b1;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;      // take the input word
		logic hash_go;   // start hash for current seed
		logic mem_rd;    // read store word at hashed index
		logic mem_wr;    // write back with bit set / update hit flags
		logic next_seed; // advance seed
		logic clr_wr;    // clearing pass write
		logic out_load;  // latch result into output register
	} ibf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hash_done;
		logic last_seed;
		logic clr_last;
		logic is_query;
	} ibf_sts_t;

endpackage

>>> rtl/ibf_mul.sv
// ----------------------------------------------------------------------------
// ibf_mul
// 64x64 low-half multiplier built from three 32x32 partial products, one per cycle.
// ----------------------------------------------------------------------------
module ibf_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);
	logic [1:0]  step_q;
	logic        busy_q;
	logic [63:0] a_q, b_q, acc_q;
	logic [31:0] pa, pb;
	logic [63:0] pp;

	always_comb begin
		case (step_q)
			2'd0: begin pa = a_q[31:0];  pb = b_q[31:0];  end
			2'd1: begin pa = a_q[63:32]; pb = b_q[31:0];  end
			default: begin pa = a_q[31:0]; pb = b_q[63:32]; end
		endcase
	end
	assign pp = {32'd0, pa} * {32'd0, pb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				step_q <= step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= 64'd0;
		end else if (busy_q) begin
			if (step_q == 2'd0) acc_q <= pp;
			else acc_q <= acc_q + {pp[31:0], 32'd0};
		end
	end
	assign p = acc_q;
endmodule

>>> rtl/ibf_hash.sv
// ----------------------------------------------------------------------------
// ibf_hash
// XXH64 of one 8-byte word, sequenced over a shared multiplier.
// ----------------------------------------------------------------------------
module ibf_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] word,
	input  logic [63:0] seed,
	output logic        done,
	output logic [63:0] hash
);
	typedef enum logic [6:0] {
		H_IDLE = 7'b0000001,
		H_M1   = 7'b0000010,
		H_M2   = 7'b0000100,
		H_M3   = 7'b0001000,
		H_M4   = 7'b0010000,
		H_M5   = 7'b0100000,
		H_FIN  = 7'b1000000
	} hstate_t;

	hstate_t     st_q;
	logic [63:0] h_q, v_q;
	logic        m_start, m_done;
	logic [63:0] m_a, m_b, m_p, k, r;

	ibf_mul u_mul (.clk, .arst_n, .start(m_start), .a(m_a), .b(m_b), .done(m_done), .p(m_p));

	assign k = {m_p[32:0], m_p[63:33]};
	assign r = h_q ^ m_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= H_IDLE;
		else begin
			case (st_q)
				H_IDLE: if (start) st_q <= H_M1;
				H_M1:   if (m_done) st_q <= H_M2;
				H_M2:   if (m_done) st_q <= H_M3;
				H_M3:   if (m_done) st_q <= H_M4;
				H_M4:   if (m_done) st_q <= H_M5;
				H_M5:   if (m_done) st_q <= H_FIN;
				H_FIN:  st_q <= H_IDLE;
				default: st_q <= H_IDLE;
			endcase
		end
	end

	always_comb begin
		m_start = 1'b0;
		m_a = v_q;
		m_b = ibf_pkg::XP2;
		case (st_q)
			H_IDLE: begin m_start = start; m_a = word; m_b = ibf_pkg::XP2; end
			H_M1: begin m_start = m_done; m_a = k; m_b = ibf_pkg::XP1; end
			H_M2: begin
				m_start = m_done;
				m_a = {r[36:0], r[63:37]};
				m_b = ibf_pkg::XP1;
			end
			H_M3: begin
				m_start = m_done;
				m_a = (m_p + ibf_pkg::XP4) ^ ((m_p + ibf_pkg::XP4) >> 33);
				m_b = ibf_pkg::XP2;
			end
			H_M4: begin m_start = m_done; m_a = m_p ^ (m_p >> 29); m_b = ibf_pkg::XP3; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == H_IDLE && start) h_q <= seed + ibf_pkg::XP5 + 64'd8;
		if (st_q == H_M5 && m_done) v_q <= m_p ^ (m_p >> 32);
	end
	assign done = (st_q == H_FIN);
	assign hash = v_q;
endmodule

>>> rtl/ibf_datapath.sv
// ----------------------------------------------------------------------------
// ibf_datapath
// Input word, seed counter, hash unit, bit store, hit flags, result register.
// ----------------------------------------------------------------------------
module ibf_datapath #(
	parameter int MAX_LOGICAL_BITS_LOG2 = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ibf_pkg::ibf_cmd_t cmd,
	output ibf_pkg::ibf_sts_t sts,
	input  logic              req_type,
	input  logic [63:0]       key,
	input  logic              filter_select,
	input  logic [4:0]        hash_count,
	input  logic [4:0]        logical_size_log2,
	output logic              in_filter_a,
	output logic              in_filter_b
);
	localparam int PHYS_W = MAX_LOGICAL_BITS_LOG2 + 1;
	localparam int ADDR_W = PHYS_W - ibf_pkg::BIT_SEL_W;
	localparam int DEPTH = 1 << ADDR_W;
	localparam logic [4:0] SIZE_MAX = 5'(MAX_LOGICAL_BITS_LOG2);

	logic [63:0] store [DEPTH];
	logic        req_q, sel_q, hit_a_q, hit_b_q;
	logic [63:0] key_q, hash;
	logic [4:0]  seed_q, n_q;
	logic [4:0]  size_eff;
	logic [MAX_LOGICAL_BITS_LOG2-1:0] mask;
	logic [PHYS_W-1:0] phys;
	logic [ADDR_W-1:0] addr_q, clr_q;
	logic [5:0]  bit_q;
	logic [63:0] rd_q;
	logic        h_done;

	ibf_hash u_hash (.clk, .arst_n, .start(cmd.hash_go), .word(key_q),
		.seed({59'd0, seed_q}), .done(h_done), .hash(hash));

	always_comb begin
		size_eff = logical_size_log2;
		if (size_eff < ibf_pkg::SIZE_MIN_LOG2) size_eff = ibf_pkg::SIZE_MIN_LOG2;
		if (size_eff > SIZE_MAX) size_eff = SIZE_MAX;
		mask = MAX_LOGICAL_BITS_LOG2'((PHYS_W'(1) << size_eff) - PHYS_W'(1));
		phys = {hash[MAX_LOGICAL_BITS_LOG2-1:0] & mask, (req_q == ibf_pkg::REQ_INSERT) & sel_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			key_q <= key;
			sel_q <= filter_select;
			if (hash_count < ibf_pkg::HASH_MIN) n_q <= ibf_pkg::HASH_MIN;
			else if (hash_count > ibf_pkg::HASH_MAX) n_q <= ibf_pkg::HASH_MAX;
			else n_q <= hash_count;
		end
		if (h_done) begin
			addr_q <= phys[PHYS_W-1:ibf_pkg::BIT_SEL_W];
			bit_q  <= phys[ibf_pkg::BIT_SEL_W-1:0];
		end
		if (cmd.mem_rd) rd_q <= store[addr_q];
		if (cmd.mem_wr && req_q == ibf_pkg::REQ_INSERT)
			store[addr_q] <= rd_q | (64'd1 << bit_q);
		if (cmd.clr_wr) store[clr_q] <= 64'd0;
		if (cmd.out_load) begin
			in_filter_a <= hit_a_q;
			in_filter_b <= hit_b_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= 5'd0;
			clr_q   <= '0;
			hit_a_q <= 1'b1;
			hit_b_q <= 1'b1;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + ADDR_W'(1);
			if (cmd.load) begin
				seed_q  <= 5'd0;
				hit_a_q <= 1'b1;
				hit_b_q <= 1'b1;
			end else if (cmd.next_seed) seed_q <= seed_q + 5'd1;
			if (cmd.mem_wr && req_q == ibf_pkg::REQ_QUERY) begin
				if (!rd_q[bit_q]) hit_a_q <= 1'b0;
				if (!rd_q[bit_q + 6'd1]) hit_b_q <= 1'b0;
			end
		end
	end

	assign sts.hash_done = h_done;
	assign sts.last_seed = (seed_q + 5'd1 == n_q);
	assign sts.clr_last  = (clr_q == ADDR_W'(DEPTH - 1));
	assign sts.is_query  = (req_q == ibf_pkg::REQ_QUERY);
endmodule

>>> rtl/ibf_ctrl.sv
// ----------------------------------------------------------------------------
// ibf_ctrl
// Sequencer: clearing pass, per-seed hash/read/write, result handshake.
// ----------------------------------------------------------------------------
module ibf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ibf_pkg::ibf_sts_t sts,
	output ibf_pkg::ibf_cmd_t cmd
);
	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_HASH  = 6'b000100,
		S_READ  = 6'b001000,
		S_WRITE = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t st_q;
	logic   ov_q;
	logic   out_free;

	assign out_free = !ov_q || out_ready;
	assign in_ready = (st_q == S_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		cmd = '0;
		case (st_q)
			S_CLEAR: cmd.clr_wr = 1'b1;
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_HASH: cmd.hash_go = 1'b0;
			S_READ: cmd.mem_rd = 1'b1;
			S_WRITE: begin
				cmd.mem_wr = 1'b1;
				cmd.next_seed = !sts.last_seed;
			end
			S_DONE: cmd.out_load = out_free;
			default: ;
		endcase
		if (st_q == S_IDLE && in_valid) cmd.hash_go = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
			ov_q <= 1'b0;
		end else begin
			if (st_q == S_DONE && out_free) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			case (st_q)
				S_CLEAR: if (sts.clr_last) st_q <= S_IDLE;
				S_IDLE: if (in_valid) st_q <= S_HASH;
				S_HASH: if (sts.hash_done) st_q <= S_READ;
				S_READ: st_q <= S_WRITE;
				S_WRITE: begin
					if (!sts.last_seed) st_q <= S_HASH;
					else if (sts.is_query) st_q <= S_DONE;
					else st_q <= S_IDLE;
				end
				S_DONE: if (out_free) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/ibf_core.sv
// ----------------------------------------------------------------------------
// ibf_core
// Joins the sequencer and datapath; starts each hash in the cycle after load
// or after the seed steps.
// ----------------------------------------------------------------------------
module ibf_core #(
	parameter int MAX_LOGICAL_BITS_LOG2 = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [63:0] key,
	input  logic        filter_select,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        in_filter_a,
	output logic        in_filter_b,
	input  logic [4:0]  hash_count,
	input  logic [4:0]  logical_size_log2
);
	ibf_pkg::ibf_cmd_t cmd, cmd_dp;
	ibf_pkg::ibf_sts_t sts;
	logic first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) first_q <= 1'b0;
		else first_q <= cmd.load | cmd.next_seed;
	end

	always_comb begin
		cmd_dp = cmd;
		cmd_dp.hash_go = cmd.hash_go | first_q;
	end

	ibf_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.sts, .cmd);
	ibf_datapath #(.MAX_LOGICAL_BITS_LOG2(MAX_LOGICAL_BITS_LOG2)) u_dp (
		.clk, .arst_n, .cmd(cmd_dp), .sts, .req_type, .key, .filter_select,
		.hash_count, .logical_size_log2, .in_filter_a, .in_filter_b);
endmodule

>>> rtl/interleaved_bloom_filter.sv
// ----------------------------------------------------------------------------
// interleaved_bloom_filter
// Two Bloom filters interleaved in one bit store, XXH64-seeded indexing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries req_type, key, filter_select.
//   An insert sets one bit per hash in the selected filter and gives no word
//   out; a query returns one word (in_filter_a, in_filter_b) on the output
//   channel (out_valid/out_ready), held in an output register.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   hash_count (index 0) and logical_size_log2 (index 1); always ready.
//   Each hash runs XXH64: five 64-bit multiplies on one shared 32x32
//   multiplier, plus a start and a finish step, then a store read and
//   write.
//   An item runs one such hash per seed for hash_count seeds; one item at a
//   time. A query word shows in the output register after its last hash.
//   After reset the store's 2^(MAX_LOGICAL_BITS_LOG2+1)/64 words (2048 by
//   default) are swept to zero, one word a cycle; in_ready is low until it
//   ends. A query waits for a free output register if the receiver
//   stalls; in_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module interleaved_bloom_filter #(
	parameter int MAX_LOGICAL_BITS_LOG2 = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [63:0] key,
	input  logic        filter_select,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        in_filter_a,
	output logic        in_filter_b,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);
	logic [4:0] hash_count_q, size_log2_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_count_q <= ibf_pkg::HASH_CNT_RST;
			size_log2_q  <= 5'(MAX_LOGICAL_BITS_LOG2);
		end else if (cfg_valid) begin
			case (cfg_index)
				ibf_pkg::CFG_HASH_COUNT: hash_count_q <= cfg_data;
				ibf_pkg::CFG_SIZE_LOG2:  size_log2_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	ibf_core #(.MAX_LOGICAL_BITS_LOG2(MAX_LOGICAL_BITS_LOG2)) u_core (
		.clk, .arst_n, .in_valid, .in_ready, .req_type, .key, .filter_select,
		.out_valid, .out_ready, .in_filter_a, .in_filter_b,
		.hash_count(hash_count_q), .logical_size_log2(size_log2_q));
endmodule

>>> rtl/ibf_checker.sv
// ----------------------------------------------------------------------------
// ibf_checker
// Port-level checks of the interleaved Bloom filter.
// ----------------------------------------------------------------------------
module ibf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic in_filter_a,
	input logic in_filter_b
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(in_filter_a) && $stable(in_filter_b))
		else $error("result changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("took a word while busy");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid ##1 out_valid |-> $past(!in_ready))
		else $error("result without work");
endmodule

bind interleaved_bloom_filter ibf_checker u_ibf_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.in_filter_a, .in_filter_b);
